// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tcw_cmd_e;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_NULL      = 8'h00;
  localparam logic [7:0] ATTR_RESET     = 8'h07;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [10:0] cursor_now;
    logic [15:0] cell_word;
  } tcw_rsp_t;

endpackage

// ----- rtl/text_console_writer.sv -----
// Text console: a COLUMNS x ROWS store of 16-bit cells (attribute high byte,
// character low byte) with a cursor.
// Request channel (req_valid_i/req_ready_o, req_i) takes commands: write a
// character (newline and backspace handled), clear the screen, read a cell.
// Response channel (rsp_valid_o/rsp_ready_i, rsp_o) returns one response per
// request with the cursor after the request and, for a read, the cell word.
// cfg_we_i/cfg_wdata_i load the attribute byte; write it only while idle.
// Steps: a plain write or a newline/backspace goes from idle to the done
// state; a read passes a read state for the registered read of the cell
// memory. A clear sweeps the memory one cell per cycle. A write that runs
// off the end scrolls: one memory read and write per cycle over the upper
// rows, then the bottom row is filled.
// The cell memory has one write port and one registered read port.
// Reset: the cursor homes, the attribute becomes 7, and a sweep of
// every cell zeroes the memory with req_ready_o low.
// A stalled response is held in the output register; one more request is
// still taken and waits, finished, until that register frees up.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  tcw_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output tcw_rsp_t rsp_o,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AddrW = $clog2(CELLS);

  logic [7:0]       attr_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .AddrW  (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .attr_i     (attr_q),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  tcw_cell_ram #(
    .Depth(CELLS),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  a_idle_write_on_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && req_ready_o |-> req_valid_i)
    else $error("cell write while idle without a request");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write to the same cell in one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while previous one in flight");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (CELLS > 2048) || (32'(rsp_o.cursor_now) < CELLS))
    else $error("cursor beyond the screen");

endmodule

// ----- rtl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AddrW   = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       attr_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  tcw_req_t         req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output tcw_rsp_t         rsp_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [15:0]      mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [15:0]      mem_rdata_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = COLUMNS * (ROWS - 1);
  localparam int ColW  = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic             init_q;
  logic [AddrW-1:0] cnt_q;
  logic [AddrW-1:0] cursor_q;
  logic [ColW-1:0]  col_q;
  logic [15:0]      fill_q;
  logic [15:0]      word_q;
  logic             rd_ok_q;
  tcw_rsp_t         rsp_q;
  logic             rsp_valid_q;

  logic             accept;
  logic [AddrW:0]   cur_ext;
  logic [AddrW:0]   cur_d;
  logic [ColW-1:0]  col_d;
  logic             wrap;
  logic             is_nl;
  logic             is_bs;
  logic             at_home;
  logic [AddrW:0]   copy_src;

  assign accept  = req_valid_i && req_ready_o;
  assign cur_ext = {1'b0, cursor_q};
  assign is_nl   = req_i.char_code == CHAR_NEWLINE;
  assign is_bs   = req_i.char_code == CHAR_BACKSPACE;
  assign at_home = cursor_q == '0;

  always_comb begin
    cur_d = cur_ext;
    col_d = col_q;
    if (is_nl) begin
      cur_d = cur_ext - (AddrW+1)'(col_q) + (AddrW+1)'(COLUMNS);
      col_d = '0;
    end else if (is_bs) begin
      if (!at_home) begin
        cur_d = cur_ext - 1'b1;
        col_d = (col_q == '0) ? ColW'(COLUMNS - 1) : col_q - 1'b1;
      end
    end else begin
      cur_d = cur_ext + 1'b1;
      col_d = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
    end
  end

  assign wrap     = cur_d >= (AddrW+1)'(CELLS);
  assign copy_src = {1'b0, cnt_q} + (AddrW+1)'(COLUMNS);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cursor_q;
    mem_wdata_o = {attr_i, CHAR_SPACE};
    mem_re_o    = 1'b0;
    mem_raddr_o = AddrW'(req_i.cell_index);
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.command == CMD_WRITE && !is_nl && !(is_bs && at_home)) begin
          mem_we_o = 1'b1;
          if (is_bs) begin
            mem_waddr_o = cursor_q - 1'b1;
          end else begin
            mem_wdata_o = {attr_i, req_i.char_code};
          end
        end
        mem_re_o = accept && req_i.command == CMD_READ;
      end
      ST_COPY: begin
        mem_re_o    = cnt_q != AddrW'(LAST);
        mem_raddr_o = copy_src[AddrW-1:0];
        mem_we_o    = cnt_q != '0;
        mem_waddr_o = cnt_q - 1'b1;
        mem_wdata_o = mem_rdata_i;
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
      end
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = fill_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      fill_q      <= '0;
      word_q      <= '0;
      rd_ok_q     <= 1'b0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i && state_q != ST_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == AddrW'(CELLS - 1)) begin
            cnt_q   <= '0;
            init_q  <= 1'b0;
            state_q <= init_q ? ST_IDLE : ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            word_q <= '0;
            case (req_i.command)
              CMD_WRITE: begin
                if (wrap) begin
                  cursor_q <= AddrW'(LAST);
                  col_q    <= '0;
                  cnt_q    <= '0;
                  state_q  <= ST_COPY;
                end else begin
                  cursor_q <= cur_d[AddrW-1:0];
                  col_q    <= col_d;
                  state_q  <= ST_DONE;
                end
              end
              CMD_CLEAR: begin
                fill_q   <= {attr_i, CHAR_NULL};
                cursor_q <= '0;
                col_q    <= '0;
                cnt_q    <= '0;
                state_q  <= ST_CLEAR;
              end
              CMD_READ: begin
                rd_ok_q <= 32'(req_i.cell_index) < CELLS;
                state_q <= ST_READ;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          word_q  <= rd_ok_q ? mem_rdata_i : '0;
          state_q <= ST_DONE;
        end
        ST_COPY: begin
          if (cnt_q == AddrW'(LAST)) begin
            state_q <= ST_FILL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FILL: begin
          if (cnt_q == AddrW'(CELLS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (!rsp_valid_q || rsp_ready_i) begin
            rsp_valid_q      <= 1'b1;
            rsp_q.cursor_now <= 11'(cursor_q);
            rsp_q.cell_word  <= word_q;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = state_q == ST_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
